FILE: src/onc_pkg.sv
// Shared types and constants of the octahedral normal codec.
package onc_pkg;

  localparam int COMP_BITS_DEF = 16;
  localparam int NORM_HALF     = 6;
  localparam int NORM_SHIFT    = 2 * NORM_HALF;

  typedef enum logic {
    KIND_ENC = 1'b0,
    KIND_DEC = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       deg;
    logic [2:0] sgn;
  } ctl_t;

endpackage

FILE: src/octahedral_normal_codec.sv
// Octahedral normal codec: a fully pipelined encoder and decoder sharing one datapath.
// Every word (encode or decode) takes the same path through the registered stages; one word
// enters per cycle while the output is not held. The pipeline depth is set mostly by the
// square root, which resolves one root bit per stage over COMP_BITS+7 stages,
// and by the three-lane restoring divider, which resolves one quotient bit per stage over
// COMP_BITS+1 stages. While a result word waits with out_tready low, the whole pipeline
// holds and in_tready is low.
module octahedral_normal_codec #(
  parameter int COMP_BITS = onc_pkg::COMP_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // comp_x, comp_y, comp_z, enc_u, enc_v from the lowest bit up, zero filled.
  input  logic [((5*COMP_BITS+7)/8)*8-1:0]       in_tdata,
  // kind.
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // out_u, out_v, out_x, out_y, out_z from the lowest bit up, zero filled.
  output logic [((5*COMP_BITS+7)/8)*8-1:0]       out_tdata,
  // degenerate.
  output logic                                   out_tuser
);

  localparam int B    = COMP_BITS;
  localparam int DW_W = ((5*B+7)/8)*8;
  localparam int LW   = B + 2;
  localparam int RW   = B + onc_pkg::NORM_HALF + 1;
  localparam int RADW = 2 * RW;
  localparam int QW   = B + 1;
  localparam int NW   = 2 * B + onc_pkg::NORM_HALF + 1;
  localparam int DW   = B + onc_pkg::NORM_HALF + 2;

  logic en;
  logic out_vld_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // Stage 1: input registers.
  logic                s1_vld_r;
  onc_pkg::kind_t      s1_kind_r;
  logic [B-1:0]        s1_x_r, s1_y_r, s1_z_r, s1_u_r, s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r <= onc_pkg::kind_t'(in_tuser);
      s1_x_r    <= in_tdata[B-1:0];
      s1_y_r    <= in_tdata[2*B-1:B];
      s1_z_r    <= in_tdata[3*B-1:2*B];
      s1_u_r    <= in_tdata[4*B-1:3*B];
      s1_v_r    <= in_tdata[5*B-1:4*B];
    end
  end

  // Stage 2: magnitudes, L1 norm and decoded pair.
  logic signed [B:0]   xe, ye, ze;
  logic [B:0]          ax_c, ay_c, az_c;
  logic [B+1:0]        pu_c, pv_c, one_c, mpu_c, mpv_c, s_c, nz_c;
  logic                s2_vld_r;
  onc_pkg::ctl_t       s2_ctl_nxt, s2_ctl_r;
  logic [2:0][B:0]     s2_m_nxt, s2_m_r;
  logic [B+1:0]        s2_e_nxt, s2_e_r;

  always_comb begin
    xe    = {s1_x_r[B-1], s1_x_r};
    ye    = {s1_y_r[B-1], s1_y_r};
    ze    = {s1_z_r[B-1], s1_z_r};
    ax_c  = xe[B] ? (B+1)'(-xe) : (B+1)'(xe);
    ay_c  = ye[B] ? (B+1)'(-ye) : (B+1)'(ye);
    az_c  = ze[B] ? (B+1)'(-ze) : (B+1)'(ze);
    one_c = (B+2)'(1) << B;
    pu_c  = {1'b0, s1_u_r, 1'b0};
    pv_c  = {1'b0, s1_v_r, 1'b0};
    mpu_c = s1_u_r[B-1] ? pu_c - one_c : one_c - pu_c;
    mpv_c = s1_v_r[B-1] ? pv_c - one_c : one_c - pv_c;
    s_c   = (B+2)'(ax_c) + (B+2)'(ay_c) + (B+2)'(az_c);
    nz_c  = one_c - mpu_c - mpv_c;
    s2_ctl_nxt.kind = s1_kind_r;
    if (s1_kind_r == onc_pkg::KIND_ENC) begin
      s2_ctl_nxt.deg = (s_c == '0);
      s2_ctl_nxt.sgn = {ze[B], ye[B], xe[B]};
      s2_m_nxt       = {az_c, ay_c, ax_c};
      s2_e_nxt       = s_c;
    end else begin
      s2_ctl_nxt.deg = 1'b0;
      s2_ctl_nxt.sgn = {nz_c[B+1], !s1_v_r[B-1], !s1_u_r[B-1]};
      s2_m_nxt       = {(B+1)'(0), mpv_c[B:0], mpu_c[B:0]};
      s2_e_nxt       = nz_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctl_r <= s2_ctl_nxt;
      s2_m_r   <= s2_m_nxt;
      s2_e_r   <= s2_e_nxt;
    end
  end

  // Stage 3: fold over the diagonals into three lanes.
  logic [LW-1:0]       m0_c, m1_c, s3one_c;
  logic                s3_vld_r;
  onc_pkg::ctl_t       s3_ctl_r;
  logic [2:0][LW-1:0]  s3_lane_nxt, s3_lane_r;

  always_comb begin
    m0_c    = LW'(s2_m_r[0]);
    m1_c    = LW'(s2_m_r[1]);
    s3one_c = LW'(1) << B;
    if (s2_ctl_r.kind == onc_pkg::KIND_ENC) begin
      if (s2_ctl_r.sgn[2]) begin
        s3_lane_nxt[0] = s2_ctl_r.sgn[0] ? m1_c : (s2_e_r << 1) - m1_c;
        s3_lane_nxt[1] = s2_ctl_r.sgn[1] ? m0_c : (s2_e_r << 1) - m0_c;
      end else begin
        s3_lane_nxt[0] = s2_ctl_r.sgn[0] ? s2_e_r - m0_c : s2_e_r + m0_c;
        s3_lane_nxt[1] = s2_ctl_r.sgn[1] ? s2_e_r - m1_c : s2_e_r + m1_c;
      end
      s3_lane_nxt[2] = s2_e_r;
    end else begin
      s3_lane_nxt[0] = s2_ctl_r.sgn[2] ? s3one_c - m1_c : m0_c;
      s3_lane_nxt[1] = s2_ctl_r.sgn[2] ? s3one_c - m0_c : m1_c;
      s3_lane_nxt[2] = s2_ctl_r.sgn[2] ? LW'(0) - s2_e_r : s2_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctl_r  <= s2_ctl_r;
      s3_lane_r <= s3_lane_nxt;
    end
  end

  // Stage 4: squares.
  logic                  s4_vld_r;
  onc_pkg::ctl_t         s4_ctl_r;
  logic [2:0][LW-1:0]    s4_lane_r;
  logic [2:0][2*LW-1:0]  s4_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ctl_r  <= s3_ctl_r;
      s4_lane_r <= s3_lane_r;
      for (int i = 0; i < 3; i++) begin
        s4_sq_r[i] <= s3_lane_r[i] * s3_lane_r[i];
      end
    end
  end

  // Square root, one root bit per stage; index 0 holds the scaled squared length.
  logic [2*LW+1:0]      len_c;
  logic                 sq_vld_r  [0:RW];
  onc_pkg::ctl_t        sq_ctl_r  [0:RW];
  logic [2:0][LW-1:0]   sq_lane_r [0:RW];
  logic [RADW-1:0]      sq_rad_r  [0:RW];
  logic [RW+1:0]        sq_rem_r  [0:RW];
  logic [RW-1:0]        sq_root_r [0:RW];

  assign len_c = (2*LW+2)'(s4_sq_r[0]) + (2*LW+2)'(s4_sq_r[1]) + (2*LW+2)'(s4_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r[0] <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ctl_r[0]  <= s4_ctl_r;
      sq_lane_r[0] <= s4_lane_r;
      sq_rad_r[0]  <= RADW'(len_c[2*B:0]) << onc_pkg::NORM_SHIFT;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar j = 1; j <= RW; j++) begin : g_sqrt
    logic [RW+3:0] t_c, trial_c;
    logic [RW+1:0] rem_nxt;
    logic [RW-1:0] root_nxt;

    always_comb begin
      t_c     = {sq_rem_r[j-1], sq_rad_r[j-1][RADW-1-2*(j-1) -: 2]};
      trial_c = (RW+4)'({sq_root_r[j-1], 2'b01});
      if (t_c >= trial_c) begin
        rem_nxt  = (RW+2)'(t_c - trial_c);
        root_nxt = {sq_root_r[j-1][RW-2:0], 1'b1};
      end else begin
        rem_nxt  = (RW+2)'(t_c);
        root_nxt = {sq_root_r[j-1][RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[j] <= 1'b0;
      end else if (en) begin
        sq_vld_r[j] <= sq_vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_ctl_r[j]  <= sq_ctl_r[j-1];
        sq_lane_r[j] <= sq_lane_r[j-1];
        sq_rad_r[j]  <= sq_rad_r[j-1];
        sq_rem_r[j]  <= rem_nxt;
        sq_root_r[j] <= root_nxt;
      end
    end
  end

  // Divider, three lanes, one quotient bit per stage; index 0 is the setup.
  logic [2:0][NW-1:0]   num_c;
  logic [2:0][DW-1:0]   den_c;
  logic                 dv_vld_r  [0:QW];
  onc_pkg::ctl_t        dv_ctl_r  [0:QW];
  logic [2:0][DW-1:0]   dv_den_r  [0:QW];
  logic [2:0][DW-1:0]   dv_rem_r  [0:QW];
  logic [2:0][QW-1:0]   dv_low_r  [0:QW];
  logic [2:0][QW-1:0]   dv_q_r    [0:QW];

  always_comb begin
    if (sq_ctl_r[RW].kind == onc_pkg::KIND_ENC) begin
      for (int i = 0; i < 2; i++) begin
        num_c[i] = (NW'(sq_lane_r[RW][i]) << B) + NW'(sq_lane_r[RW][2]);
        den_c[i] = DW'(sq_lane_r[RW][2]) << 1;
      end
      num_c[2] = '0;
      den_c[2] = DW'(1);
    end else begin
      for (int i = 0; i < 3; i++) begin
        num_c[i] = (NW'(sq_lane_r[RW][i]) << (B + onc_pkg::NORM_HALF))
                   + NW'(sq_root_r[RW]);
        den_c[i] = DW'(sq_root_r[RW]) << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= sq_vld_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_ctl_r[0] <= sq_ctl_r[RW];
      dv_den_r[0] <= den_c;
      dv_q_r[0]   <= '0;
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= DW'(num_c[i][NW-1:QW]);
        dv_low_r[0][i] <= num_c[i][QW-1:0];
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [2:0][DW:0]   t_c;
    logic [2:0][DW-1:0] rem_nxt;
    logic [2:0][QW-1:0] q_nxt;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t_c[i] = {dv_rem_r[k-1][i], dv_low_r[k-1][i][QW-k]};
        if (t_c[i] >= {1'b0, dv_den_r[k-1][i]}) begin
          rem_nxt[i] = DW'(t_c[i] - {1'b0, dv_den_r[k-1][i]});
          q_nxt[i]   = {dv_q_r[k-1][i][QW-2:0], 1'b1};
        end else begin
          rem_nxt[i] = DW'(t_c[i]);
          q_nxt[i]   = {dv_q_r[k-1][i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (en) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_ctl_r[k] <= dv_ctl_r[k-1];
        dv_den_r[k] <= dv_den_r[k-1];
        dv_low_r[k] <= dv_low_r[k-1];
        dv_rem_r[k] <= rem_nxt;
        dv_q_r[k]   <= q_nxt;
      end
    end
  end

  // Output stage: saturation, signs and packing.
  localparam logic [QW-1:0] MAXU = QW'((1 << B) - 1);
  localparam logic [QW-1:0] HALF = QW'(1 << (B - 1));
  localparam logic [B-1:0]  MID  = B'(1 << (B - 1));

  logic [2:0][B-1:0] comp_c;
  logic [1:0][B-1:0] code_c;
  logic [QW-1:0]     qa_c;
  logic              deg_c;
  logic [DW_W-1:0]   out_data_nxt, out_data_r;
  logic              out_user_r;

  always_comb begin
    qa_c   = '0;
    comp_c = '0;
    code_c = '0;
    deg_c  = 1'b0;
    if (dv_ctl_r[QW].kind == onc_pkg::KIND_ENC) begin
      deg_c = dv_ctl_r[QW].deg;
      for (int i = 0; i < 2; i++) begin
        if (deg_c) begin
          code_c[i] = MID;
        end else begin
          code_c[i] = (dv_q_r[QW][i] > MAXU) ? MAXU[B-1:0] : dv_q_r[QW][i][B-1:0];
        end
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (dv_ctl_r[QW].sgn[i]) begin
          qa_c      = (dv_q_r[QW][i] > HALF) ? HALF : dv_q_r[QW][i];
          comp_c[i] = B'(QW'(0) - qa_c);
        end else begin
          qa_c      = (dv_q_r[QW][i] > HALF - QW'(1)) ? HALF - QW'(1) : dv_q_r[QW][i];
          comp_c[i] = qa_c[B-1:0];
        end
      end
    end
    out_data_nxt = DW_W'({comp_c[2], comp_c[1], comp_c[0], code_c[1], code_c[0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= deg_c;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_deg_mid : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[B-1:0] == MID && out_tdata[2*B-1:B] == MID)
    else $error("degenerate word without midpoint codes");

  a_deg_no_vec : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[5*B-1:2*B] == '0)
    else $error("degenerate word with nonzero vector");

  a_root_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld_r[RW] && sq_ctl_r[RW].kind == onc_pkg::KIND_DEC |-> sq_root_r[RW] != '0)
    else $error("decode length root is zero");

  a_enc_quot : assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[QW] && dv_ctl_r[QW].kind == onc_pkg::KIND_ENC && !dv_ctl_r[QW].deg
    |-> dv_q_r[QW][0] <= MAXU + QW'(1) && dv_q_r[QW][1] <= MAXU + QW'(1))
    else $error("encode quotient out of range");

endmodule

FILE: verif/octahedral_normal_codec_tb.sv
// Self-checking testbench for the octahedral normal codec with random stream pacing.
module octahedral_normal_codec_tb;

  localparam int CB = onc_pkg::COMP_BITS_DEF;
  localparam int DW = ((5 * CB + 7) / 8) * 8;
  localparam int DRAIN = 2 * CB + 30;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_LEN = 400;

  typedef struct {
    onc_pkg::kind_t  kind;
    logic [CB-1:0]   x, y, z, u, v;
  } normal_word_t;

  typedef struct {
    logic [CB-1:0] u, v, x, y, z;
    logic          deg;
  } codec_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DW-1:0] out_tdata;
  logic out_tuser;

  normal_word_t  pending_words[$];
  codec_result_t predicted_words[$];
  normal_word_t  cur_word;
  int errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_cnt = 0;
  int sent_cnt = 0;
  int recv_cnt = 0;
  int idle_cycles = 0;
  bit hold_done = 1'b0;

  octahedral_normal_codec #(.COMP_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [CB-1:0] octa_code(longint num, longint s);
    longint q;
    q = ((num + s) * (longint'(1) << CB) + s) / (2 * s);
    return (q > (longint'(1) << CB) - 1) ? {CB{1'b1}} : q[CB-1:0];
  endfunction

  function automatic logic [CB-1:0] unit_comp(longint n, longint m);
    longint a, q, lim;
    a = (n < 0 ? -n : n) << (CB - 1 + onc_pkg::NORM_HALF);
    q = (2 * a + m) / (2 * m);
    lim = longint'(1) << (CB - 1);
    if (n < 0) begin
      if (q > lim) q = lim;
      q = -q;
    end else if (q > lim - 1) begin
      q = lim - 1;
    end
    return q[CB-1:0];
  endfunction

  function automatic longint absl(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic codec_result_t predict_normal(normal_word_t w);
    codec_result_t r;
    longint x, y, z, s, rx, ry, one, px, py, nx, ny, nz, m;
    r = '{default: '0};
    one = longint'(1) << CB;
    if (w.kind == onc_pkg::KIND_ENC) begin
      x = longint'(signed'(w.x));
      y = longint'(signed'(w.y));
      z = longint'(signed'(w.z));
      s = absl(x) + absl(y) + absl(z);
      if (s == 0) begin
        r.deg = 1'b1;
        r.u = CB'(one >> 1);
        r.v = CB'(one >> 1);
      end else begin
        rx = x;
        ry = y;
        if (z < 0) begin
          rx = (s - absl(y)) * (x >= 0 ? 1 : -1);
          ry = (s - absl(x)) * (y >= 0 ? 1 : -1);
        end
        r.u = octa_code(rx, s);
        r.v = octa_code(ry, s);
      end
    end else begin
      px = 2 * longint'(w.u) - one;
      py = 2 * longint'(w.v) - one;
      nz = one - absl(px) - absl(py);
      nx = px;
      ny = py;
      if (nz < 0) begin
        nx = (one - absl(py)) * (px >= 0 ? 1 : -1);
        ny = (one - absl(px)) * (py >= 0 ? 1 : -1);
      end
      m = int_sqrt((nx * nx + ny * ny + nz * nz) << onc_pkg::NORM_SHIFT);
      if (m == 0) m = 1;
      r.x = unit_comp(nx, m);
      r.y = unit_comp(ny, m);
      r.z = unit_comp(nz, m);
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on word %0d field %s: got %0h expected %0h", recv_cnt, field, got, want);
    errors++;
  endtask

  function automatic int draw_gap(int idx);
    if ((idx / 150) % 3 == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  task automatic add_word(onc_pkg::kind_t k, int x, int y, int z, int u, int v);
    normal_word_t w;
    w.kind = k;
    w.x = x[CB-1:0];
    w.y = y[CB-1:0];
    w.z = z[CB-1:0];
    w.u = u[CB-1:0];
    w.v = v[CB-1:0];
    pending_words.push_back(w);
  endtask

  function automatic int rand_comp();
    unique case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 64)) - 32;
      2: return 0;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int rand_code();
    unique case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 65535 : 0;
      1: return 32768 + int'($urandom_range(0, 8)) - 4;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Driver: presents pending words with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted_words.push_back(predict_normal(cur_word));
        void'(pending_words.pop_front());
        sent_cnt++;
        send_gap = draw_gap(sent_cnt);
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap == 0 && pending_words.size() > 0) begin
          cur_word = pending_words[0];
          in_tvalid <= 1'b1;
          in_tuser <= cur_word.kind;
          in_tdata <= DW'({cur_word.v, cur_word.u, cur_word.z, cur_word.y, cur_word.x});
        end else begin
          in_tvalid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // Monitor: checks results and paces out_tready, with one long hold.
  always @(posedge clk) begin
    codec_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        recv_cnt++;
        if (predicted_words.size() == 0) begin
          $display("unexpected result word %0d", recv_cnt);
          errors++;
        end else begin
          want = predicted_words.pop_front();
          if (out_tdata[CB-1:0] !== want.u) report_mismatch("u", out_tdata[CB-1:0], want.u);
          if (out_tdata[2*CB-1:CB] !== want.v)
            report_mismatch("v", out_tdata[2*CB-1:CB], want.v);
          if (out_tdata[3*CB-1:2*CB] !== want.x)
            report_mismatch("x", out_tdata[3*CB-1:2*CB], want.x);
          if (out_tdata[4*CB-1:3*CB] !== want.y)
            report_mismatch("y", out_tdata[4*CB-1:3*CB], want.y);
          if (out_tdata[5*CB-1:4*CB] !== want.z)
            report_mismatch("z", out_tdata[5*CB-1:4*CB], want.z);
          if (out_tuser !== want.deg) report_mismatch("degenerate", out_tuser, want.deg);
        end
        recv_gap = draw_gap(recv_cnt + 75);
        if (!hold_done && recv_cnt >= 500) begin
          hold_cnt = HOLD_LEN;
          hold_done = 1'b1;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("octahedral_normal_codec test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    add_word(onc_pkg::KIND_ENC, 0, 0, 0, 0, 0);
    add_word(onc_pkg::KIND_ENC, 32767, 0, 0, 0, 0);
    add_word(onc_pkg::KIND_ENC, -32768, 0, 0, 0, 0);
    add_word(onc_pkg::KIND_ENC, 0, 32767, 0, 0, 0);
    add_word(onc_pkg::KIND_ENC, 0, 0, 32767, 0, 0);
    add_word(onc_pkg::KIND_ENC, 0, 0, -32768, 0, 0);
    add_word(onc_pkg::KIND_ENC, -32768, -32768, -32768, 65535, 65535);
    add_word(onc_pkg::KIND_ENC, 32767, 32767, 32767, 0, 0);
    add_word(onc_pkg::KIND_ENC, 0, 1000, -2000, 0, 0);
    add_word(onc_pkg::KIND_ENC, 1000, 0, -2000, 0, 0);
    add_word(onc_pkg::KIND_ENC, -1000, -3000, -2000, 0, 0);
    add_word(onc_pkg::KIND_ENC, 1, -1, 1, 0, 0);
    add_word(onc_pkg::KIND_DEC, 0, 0, 0, 0, 0);
    add_word(onc_pkg::KIND_DEC, 0, 0, 0, 65535, 65535);
    add_word(onc_pkg::KIND_DEC, 0, 0, 0, 32768, 32768);
    add_word(onc_pkg::KIND_DEC, 0, 0, 0, 65535, 32768);
    add_word(onc_pkg::KIND_DEC, 0, 0, 0, 0, 32768);
    add_word(onc_pkg::KIND_DEC, 0, 0, 0, 32768, 65535);
    add_word(onc_pkg::KIND_DEC, 0, 0, 0, 32768, 0);
    add_word(onc_pkg::KIND_DEC, 0, 0, 0, 0, 65535);
    add_word(onc_pkg::KIND_DEC, 0, 0, 0, 49152, 49152);
    add_word(onc_pkg::KIND_DEC, -1, -1, -1, 16384, 40000);
    // Sender pause: wait for the pipeline to drain completely.
    wait (pending_words.size() == 0 && predicted_words.size() == 0);
    for (int i = 0; i < 1800; i++) begin
      add_word(onc_pkg::kind_t'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp(),
               rand_code(), rand_code());
    end
    wait (pending_words.size() == 0 && !in_tvalid && predicted_words.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && predicted_words.size() == 0) begin
      $display("octahedral_normal_codec test passed");
    end else begin
      $display("octahedral_normal_codec test failed");
    end
    $finish;
  end

endmodule
